// File: sv/spsmv_pkg.sv
// Shared types and constants for the seven-point stencil matrix-vector core.
// Used by the controller, the datapath and the top level; depends on nothing.
package spsmv_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COEF_W = 40;
  localparam int unsigned ACC_W  = 52;
  localparam int unsigned CFG_AW = 3;

  // Register indexes on the configuration port.
  typedef logic [CFG_AW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_X    = 3'd0;
  localparam cfg_idx_t CFG_SIZE_Y    = 3'd1;
  localparam cfg_idx_t CFG_SIZE_Z    = 3'd2;
  localparam cfg_idx_t CFG_DELTA_X   = 3'd3;
  localparam cfg_idx_t CFG_DELTA_Y   = 3'd4;
  localparam cfg_idx_t CFG_DELTA_Z   = 3'd5;
  localparam cfg_idx_t CFG_SIGN_MASK = 3'd6;

  // Register reset values.
  localparam logic [6:0]  SIZE_XY_RST   = 7'd64;
  localparam logic [10:0] SIZE_Z_RST    = 11'd64;
  localparam logic [6:0]  SIGN_MASK_RST = 7'd119;

  // Request codes.
  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Stencil taps in evaluation order.
  typedef logic [2:0] tap_t;
  localparam tap_t TAP_MZ = 3'd0;
  localparam tap_t TAP_MY = 3'd1;
  localparam tap_t TAP_MX = 3'd2;
  localparam tap_t TAP_C  = 3'd3;
  localparam tap_t TAP_PX = 3'd4;
  localparam tap_t TAP_PY = 3'd5;
  localparam tap_t TAP_PZ = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic acc_clear;
    logic coef_en;
    logic mul_en;
    logic acc_en;
    logic out_load;
    tap_t tap;
  } spsmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic emit_go;
    logic out_free;
  } spsmv_sts_t;

endpackage

// File: sv/spsmv_ifs.sv
// Valid/ready channel interfaces: input items, result items and config writes.
// Depend on spsmv_pkg for the field widths.
interface spsmv_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [spsmv_pkg::DATA_W-1:0] voxel_value;
  logic [spsmv_pkg::DATA_W-1:0]      alpha;
  logic [spsmv_pkg::DATA_W-1:0]      diag_part;
  modport source (output valid, req_type, voxel_value, alpha, diag_part, input ready);
  modport sink   (input valid, req_type, voxel_value, alpha, diag_part, output ready);
endinterface

interface spsmv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [spsmv_pkg::DATA_W-1:0] product;
  logic                              saturated;
  logic                              last_voxel;
  modport source (output valid, product, saturated, last_voxel, input ready);
  modport sink   (input valid, product, saturated, last_voxel, output ready);
endinterface

interface spsmv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spsmv_pkg::CFG_AW-1:0] addr;
  logic [spsmv_pkg::DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: sv/spsmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spsmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/spsmv_ctrl.sv
// Controller: sequences one result through the seven taps of the stencil.
// Depends on spsmv_pkg for the command and status structs.
module spsmv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spsmv_pkg::spsmv_sts_t sts,
  output spsmv_pkg::spsmv_cmd_t cmd
);
  import spsmv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_COEF = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  tap_t   tap_r, tap_nxt;
  logic   in_accept;

  assign in_ready  = (state_r == S_IDLE) && !sts.busy;
  assign in_accept = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    cmd           = '0;
    cmd.tap       = tap_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_accept;
        if (in_accept && sts.emit_go) begin
          cmd.acc_clear = 1'b1;
          tap_nxt       = TAP_MZ;
          state_nxt     = S_RD;
        end
      end
      S_RD:   state_nxt = S_COEF;
      S_COEF: begin
        cmd.coef_en = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (tap_r == TAP_PZ) begin
          state_nxt = S_OUT;
        end else begin
          tap_nxt   = tap_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= TAP_MZ;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // The last tap always hands over to the output stage.
  a_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && tap_r == TAP_PZ) |=> (state_r == S_OUT))
    else $error("last tap did not move to the output stage");

  // A transfer is only taken while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (state_r == S_IDLE))
    else $error("input transfer outside the idle state");

  // A result starts at the first tap.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && sts.emit_go) |=> (state_r == S_RD && tap_r == TAP_MZ))
    else $error("result sequence did not start at the first tap");

endmodule

// File: sv/spsmv_dp.sv
// Datapath: configuration registers, positions, window and diagonal memories,
// coefficient and product arithmetic, accumulator and output register.
// Depends on spsmv_pkg and spsmv_ram.
module spsmv_dp #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spsmv_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [spsmv_pkg::DATA_W-1:0]        cfg_data,
  input  logic                                in_req_type,
  input  logic signed [spsmv_pkg::DATA_W-1:0] in_voxel_value,
  input  logic [spsmv_pkg::DATA_W-1:0]        in_alpha,
  input  logic [spsmv_pkg::DATA_W-1:0]        in_diag_part,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [spsmv_pkg::DATA_W-1:0] out_product,
  output logic                                out_saturated,
  output logic                                out_last_voxel,
  input  spsmv_pkg::spsmv_cmd_t               cmd,
  output spsmv_pkg::spsmv_sts_t               sts
);
  import spsmv_pkg::*;

  localparam int unsigned SXW = $clog2(MAX_X + 1);
  localparam int unsigned SYW = $clog2(MAX_Y + 1);
  localparam int unsigned SZW = $clog2(MAX_Z + 1);
  localparam int unsigned XW  = $clog2(MAX_X);
  localparam int unsigned YW  = $clog2(MAX_Y);
  localparam int unsigned ZW  = $clog2(MAX_Z);
  localparam int unsigned PLW = $clog2(MAX_X * MAX_Y + 1);
  localparam int unsigned PW  = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
  localparam int unsigned WAW = $clog2(2 * MAX_X * MAX_Y + 1);
  localparam int unsigned DAW = $clog2(MAX_X * MAX_Y + 1);

  // Configuration registers.
  logic [6:0]        size_x_r, size_y_r, sign_mask_r;
  logic [10:0]       size_z_r;
  logic [DATA_W-1:0] delta_x_r, delta_y_r, delta_z_r;
  logic [1:0]        settle_r;
  logic              size_wr;

  assign size_wr = cfg_we && (cfg_addr == CFG_SIZE_X || cfg_addr == CFG_SIZE_Y ||
                              cfg_addr == CFG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= SIZE_XY_RST;
      size_y_r    <= SIZE_XY_RST;
      size_z_r    <= SIZE_Z_RST;
      delta_x_r   <= '0;
      delta_y_r   <= '0;
      delta_z_r   <= '0;
      sign_mask_r <= SIGN_MASK_RST;
      settle_r    <= 2'd3;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SIZE_X:    size_x_r    <= cfg_data[6:0];
          CFG_SIZE_Y:    size_y_r    <= cfg_data[6:0];
          CFG_SIZE_Z:    size_z_r    <= cfg_data[10:0];
          CFG_DELTA_X:   delta_x_r   <= cfg_data;
          CFG_DELTA_Y:   delta_y_r   <= cfg_data;
          CFG_DELTA_Z:   delta_z_r   <= cfg_data;
          CFG_SIGN_MASK: sign_mask_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      // Hold off items until the derived sizes below have settled.
      if (cfg_we) begin
        settle_r <= 2'd3;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Clamped sizes, plane size and voxel count, one register stage each.
  logic [SXW-1:0] sx_c, sx_r;
  logic [SYW-1:0] sy_c, sy_r;
  logic [SZW-1:0] sz_c, sz_r;
  logic [PLW-1:0] plane_r;
  logic [PW-1:0]  n_r;

  always_comb begin
    if (size_x_r == 7'd0)          sx_c = SXW'(1);
    else if (32'(size_x_r) > MAX_X) sx_c = SXW'(MAX_X);
    else                           sx_c = SXW'(size_x_r);
    if (size_y_r == 7'd0)          sy_c = SYW'(1);
    else if (32'(size_y_r) > MAX_Y) sy_c = SYW'(MAX_Y);
    else                           sy_c = SYW'(size_y_r);
    if (size_z_r == 11'd0)         sz_c = SZW'(1);
    else if (32'(size_z_r) > MAX_Z) sz_c = SZW'(MAX_Z);
    else                           sz_c = SZW'(size_z_r);
  end

  always_ff @(posedge clk) begin
    sx_r    <= sx_c;
    sy_r    <= sy_c;
    sz_r    <= sz_c;
    plane_r <= PLW'(PLW'(sx_r) * PLW'(sy_r));
    n_r     <= PW'(PW'(plane_r) * PW'(sz_r));
  end

  // Stream positions and coordinates of the voxel whose result is next.
  logic [PW-1:0] p_r, o_r;
  logic [XW-1:0] x0_r;
  logic [YW-1:0] y0_r;
  logic [ZW-1:0] z0_r;
  logic          voxel_wr;

  assign voxel_wr    = cmd.accept && (in_req_type == REQ_VOXEL) && (p_r < n_r);
  assign sts.busy    = (settle_r != 2'd0);
  assign sts.emit_go = (o_r < n_r) &&
                       ((in_req_type == REQ_VOXEL) ?
                        ((p_r < n_r) && (p_r >= PW'(plane_r))) : (p_r == n_r));

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr) begin
      p_r  <= '0;
      o_r  <= '0;
      x0_r <= '0;
      y0_r <= '0;
      z0_r <= '0;
    end else begin
      if (voxel_wr) begin
        p_r <= p_r + PW'(1);
      end
      if (cmd.out_load) begin
        if ((o_r + PW'(1)) == n_r) begin
          p_r  <= '0;
          o_r  <= '0;
          x0_r <= '0;
          y0_r <= '0;
          z0_r <= '0;
        end else begin
          o_r <= o_r + PW'(1);
          if ((SXW'(x0_r) + SXW'(1)) == sx_r) begin
            x0_r <= '0;
            if ((SYW'(y0_r) + SYW'(1)) == sy_r) begin
              y0_r <= '0;
              z0_r <= z0_r + ZW'(1);
            end else begin
              y0_r <= y0_r + YW'(1);
            end
          end else begin
            x0_r <= x0_r + XW'(1);
          end
        end
      end
    end
  end

  // Neighbour address and in-grid test for the current tap.
  logic [WAW-1:0] base_a, win_raddr;
  logic           tap_ok, tap_neg;

  assign base_a  = o_r[WAW-1:0];
  assign tap_neg = sign_mask_r[cmd.tap];

  always_comb begin
    unique case (cmd.tap)
      TAP_MZ: begin
        win_raddr = base_a - WAW'(plane_r);
        tap_ok    = (z0_r != '0);
      end
      TAP_MY: begin
        win_raddr = base_a - WAW'(sx_r);
        tap_ok    = (y0_r != '0);
      end
      TAP_MX: begin
        win_raddr = base_a - WAW'(1);
        tap_ok    = (x0_r != '0);
      end
      TAP_C: begin
        win_raddr = base_a;
        tap_ok    = 1'b1;
      end
      TAP_PX: begin
        win_raddr = base_a + WAW'(1);
        tap_ok    = (SXW'(x0_r) + SXW'(1)) < sx_r;
      end
      TAP_PY: begin
        win_raddr = base_a + WAW'(sx_r);
        tap_ok    = (SYW'(y0_r) + SYW'(1)) < sy_r;
      end
      TAP_PZ: begin
        win_raddr = base_a + WAW'(plane_r);
        tap_ok    = (SZW'(z0_r) + SZW'(1)) < sz_r;
      end
      default: begin
        win_raddr = base_a;
        tap_ok    = 1'b0;
      end
    endcase
  end

  // Window of value and alpha, and delay line of diagonal sums.
  logic [2*DATA_W-1:0] win_rdata;
  logic [DATA_W-1:0]   diag_rdata;

  spsmv_ram #(.WIDTH(2 * DATA_W), .DEPTH(2 ** WAW)) u_win_ram (
    .clk   (clk),
    .we    (voxel_wr),
    .waddr (p_r[WAW-1:0]),
    .wdata ({in_alpha, in_voxel_value}),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  spsmv_ram #(.WIDTH(DATA_W), .DEPTH(2 ** DAW)) u_diag_ram (
    .clk   (clk),
    .we    (voxel_wr),
    .waddr (p_r[DAW-1:0]),
    .wdata (in_diag_part),
    .raddr (o_r[DAW-1:0]),
    .rdata (diag_rdata)
  );

  // Coefficient stage: delta times alpha, or the diagonal for the centre.
  logic [DATA_W-1:0]        delta_sel;
  logic [2*DATA_W-1:0]      dprod;
  logic [COEF_W-1:0]        coef_r;
  logic signed [DATA_W-1:0] val_r;

  always_comb begin
    unique case (cmd.tap)
      TAP_MZ, TAP_PZ: delta_sel = delta_z_r;
      TAP_MY, TAP_PY: delta_sel = delta_y_r;
      default:        delta_sel = delta_x_r;
    endcase
  end

  assign dprod = delta_sel * win_rdata[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (cmd.coef_en) begin
      val_r  <= $signed(win_rdata[DATA_W-1:0]);
      coef_r <= (cmd.tap == TAP_C) ? COEF_W'(diag_rdata) : dprod[63:24];
    end
  end

  // Product stage: coefficient split into integer and fraction parts.
  logic signed [48:0] hi_prod_r;
  logic signed [56:0] lo_prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      hi_prod_r <= $signed({1'b0, coef_r[39:24]}) * val_r;
      lo_prod_r <= $signed({1'b0, coef_r[23:0]}) * val_r;
    end
  end

  // Accumulate stage.
  logic signed [49:0]      term;
  logic signed [ACC_W-1:0] term_s, acc_r;

  assign term   = 50'(hi_prod_r) + 50'(lo_prod_r >>> 24);
  assign term_s = tap_neg ? -ACC_W'(term) : ACC_W'(term);

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_r <= '0;
    end else if (cmd.acc_en && tap_ok) begin
      acc_r <= acc_r + term_s + ((cmd.tap == TAP_C) ? ACC_W'(val_r) : ACC_W'(0));
    end
  end

  // Saturation and output register.
  logic sat_hi, sat_lo, out_valid_r;

  assign sat_hi = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:31]);
  assign sat_lo = acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:31]);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_saturated  <= sat_hi || sat_lo;
      out_last_voxel <= (o_r == (n_r - PW'(1)));
      if (sat_hi)      out_product <= 32'sh7FFF_FFFF;
      else if (sat_lo) out_product <= 32'sh8000_0000;
      else             out_product <= acc_r[DATA_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

  // Results never run ahead of the voxels taken in.
  a_order: assert property (@(posedge clk) disable iff (!rst_n) o_r <= p_r)
    else $error("result position passed input position");

  // A size write restarts the stream.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    size_wr |=> (p_r == '0 && o_r == '0))
    else $error("size write did not restart the stream");

  // A new result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

// File: sv/seven_point_stencil_matvec_core.sv
// Seven-point stencil matrix-vector core. An item that gives no result leaves the core idle;
// an item that completes a result runs the controller through the seven taps, each with
// read, coefficient, product and accumulate steps, and then an output step that waits for
// the result register to be free. No new item is taken until that result is loaded.
// After reset or a configuration write, items are held off until the derived sizes
// have settled. Reset is synchronous and active low; it clears control and
// configuration only, the voxel window and diagonal memories are not cleared.
module seven_point_stencil_matvec_core #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 1024
) (
  input logic         clk,
  input logic         rst_n,
  spsmv_in_if.sink    in_ch,
  spsmv_out_if.source out_ch,
  spsmv_cfg_if.sink   cfg_ch
);
  import spsmv_pkg::*;

  spsmv_cmd_t cmd;
  spsmv_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  spsmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spsmv_dp #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_ch.valid),
    .cfg_addr       (cfg_ch.addr),
    .cfg_data       (cfg_ch.data),
    .in_req_type    (in_ch.req_type),
    .in_voxel_value (in_ch.voxel_value),
    .in_alpha       (in_ch.alpha),
    .in_diag_part   (in_ch.diag_part),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_product    (out_ch.product),
    .out_saturated  (out_ch.saturated),
    .out_last_voxel (out_ch.last_voxel),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// File: tb/sv/seven_point_stencil_matvec_core_tb.sv
// Testbench for the seven-point stencil matrix-vector core: drives voxel, flush and
// register transfers and checks each result against a predictor held in a scoreboard.
// Depends on spsmv_pkg, the channel interfaces in spsmv_ifs and the core itself.
module seven_point_stencil_matvec_core_tb;
  import spsmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_X_MAX = 64;
  localparam int GRID_Y_MAX = 64;
  localparam int GRID_Z_MAX = 1024;
  localparam int WIN_DEPTH  = 2 * GRID_X_MAX * GRID_Y_MAX + 1;
  localparam int DIAG_DEPTH = GRID_X_MAX * GRID_Y_MAX + 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 600;

  // Neighbour offsets per tap, in tap order.
  localparam int TAP_OFS_X [7] = '{0, 0, -1, 0, 1, 0, 0};
  localparam int TAP_OFS_Y [7] = '{0, -1, 0, 0, 0, 1, 0};
  localparam int TAP_OFS_Z [7] = '{-1, 0, 0, 0, 0, 0, 1};

  typedef struct {
    logic [DATA_W-1:0] product;
    logic              saturated;
    logic              last_voxel;
  } stencil_result_t;

  // Scoreboard: keeps its own copy of the voxel window and registers and predicts
  // the stencil product of every transfer that completes a result.
  class stencil_scoreboard;
    logic [6:0]  size_x_r, size_y_r, sign_mask_r;
    logic [10:0] size_z_r;
    logic [31:0] delta_x_r, delta_y_r, delta_z_r;
    logic [63:0] window [WIN_DEPTH];
    logic [31:0] diag_ring [DIAG_DEPTH];
    int          in_pos, out_pos;
    stencil_result_t pending_q [$];
    int          errors;

    function new();
      size_x_r = SIZE_XY_RST;
      size_y_r = SIZE_XY_RST;
      size_z_r = SIZE_Z_RST;
      sign_mask_r = SIGN_MASK_RST;
      delta_x_r = '0;
      delta_y_r = '0;
      delta_z_r = '0;
      in_pos = 0;
      out_pos = 0;
      errors = 0;
    endfunction

    function int clamp_size(int v, int m);
      if (v < 1) return 1;
      if (v > m) return m;
      return v;
    endfunction

    // floor(c * v / 2^24), split so that no product overflows 64 bits.
    function longint scale_q24(longint unsigned c, longint v);
      longint hi, lo;
      hi = longint'(c >> 24);
      lo = longint'(c & 64'hFF_FFFF);
      return hi * v + ((lo * v) >>> 24);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CFG_SIZE_X: begin
          size_x_r = d[6:0];
          in_pos = 0;
          out_pos = 0;
        end
        CFG_SIZE_Y: begin
          size_y_r = d[6:0];
          in_pos = 0;
          out_pos = 0;
        end
        CFG_SIZE_Z: begin
          size_z_r = d[10:0];
          in_pos = 0;
          out_pos = 0;
        end
        CFG_DELTA_X: delta_x_r = d;
        CFG_DELTA_Y: delta_y_r = d;
        CFG_DELTA_Z: delta_z_r = d;
        CFG_SIGN_MASK: sign_mask_r = d[6:0];
        default: ;
      endcase
    endfunction

    // Accumulate the seven taps for the next output position.
    function void predict_product();
      int sx, sy, sz, plane, n, o, x0, y0, z0, x, y, z, j;
      longint acc, v, term;
      longint unsigned coef, dl;
      logic [63:0] entry;
      stencil_result_t r;
      sx = clamp_size(size_x_r, GRID_X_MAX);
      sy = clamp_size(size_y_r, GRID_Y_MAX);
      sz = clamp_size(size_z_r, GRID_Z_MAX);
      plane = sx * sy;
      n = plane * sz;
      o = out_pos;
      x0 = o % sx;
      y0 = (o / sx) % sy;
      z0 = o / plane;
      acc = 0;
      for (int t = 0; t < 7; t++) begin
        x = x0 + TAP_OFS_X[t];
        y = y0 + TAP_OFS_Y[t];
        z = z0 + TAP_OFS_Z[t];
        if (x < 0 || x >= sx || y < 0 || y >= sy || z < 0 || z >= sz) continue;
        j = o + TAP_OFS_X[t] + TAP_OFS_Y[t] * sx + TAP_OFS_Z[t] * plane;
        entry = window[j % WIN_DEPTH];
        v = longint'(signed'(entry[31:0]));
        if (t == TAP_C) begin
          term = scale_q24(diag_ring[o % DIAG_DEPTH], v);
          acc += v + (sign_mask_r[t] ? -term : term);
        end else begin
          if (t == TAP_MZ || t == TAP_PZ) dl = delta_z_r;
          else if (t == TAP_MY || t == TAP_PY) dl = delta_y_r;
          else dl = delta_x_r;
          coef = (dl * longint'(entry[63:32])) >> 24;
          term = scale_q24(coef, v);
          acc += sign_mask_r[t] ? -term : term;
        end
      end
      r.saturated = 1'b0;
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        r.saturated = 1'b1;
      end
      if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        r.saturated = 1'b1;
      end
      r.product = acc[31:0];
      r.last_voxel = (o == n - 1);
      pending_q.push_back(r);
      out_pos = o + 1;
      if (out_pos >= n) begin
        out_pos = 0;
        in_pos = 0;
      end
    endfunction

    // Note one accepted input transfer.
    function void note_input(logic rt, logic [31:0] v, logic [31:0] a, logic [31:0] d);
      int sx, sy, sz, plane, n, p;
      sx = clamp_size(size_x_r, GRID_X_MAX);
      sy = clamp_size(size_y_r, GRID_Y_MAX);
      sz = clamp_size(size_z_r, GRID_Z_MAX);
      plane = sx * sy;
      n = plane * sz;
      if (rt == REQ_VOXEL) begin
        p = in_pos;
        if (p >= n) return;
        window[p % WIN_DEPTH] = {a, v};
        diag_ring[p % DIAG_DEPTH] = d;
        in_pos = p + 1;
        if (p >= plane && out_pos < n) predict_product();
      end else if (in_pos == n && out_pos < n) begin
        predict_product();
      end
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [31:0] p, logic s, logic l);
      stencil_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no prediction waiting: product %h", p);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (p !== e.product) begin
        $error("product: expected %h, got %h", e.product, p);
        errors++;
      end
      if (s !== e.saturated) begin
        $error("saturated: expected %b, got %b", e.saturated, s);
        errors++;
      end
      if (l !== e.last_voxel) begin
        $error("last_voxel: expected %b, got %b", e.last_voxel, l);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_wanted;
  bit   hold_done;
  int   hold_count;

  spsmv_in_if  in_if ();
  spsmv_out_if out_if ();
  spsmv_cfg_if cfg_if ();

  stencil_scoreboard sb;

  seven_point_stencil_matvec_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Monitors for every transfer on the three channels.
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.addr, cfg_if.data);
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_input(in_if.req_type, in_if.voxel_value, in_if.alpha, in_if.diag_part);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.product, out_if.saturated, out_if.last_voxel);
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_count <= 0;
      hold_done <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic rt, logic [31:0] v, logic [31:0] a, logic [31:0] d);
    in_if.valid <= 1'b1;
    in_if.req_type <= rt;
    in_if.voxel_value <= v;
    in_if.alpha <= a;
    in_if.diag_part <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every predicted result, then for the block to settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(int sx, int sy, int sz, logic [31:0] dx, logic [31:0] dy,
                          logic [31:0] dz, logic [6:0] mask);
    write_cfg(CFG_SIZE_X, sx);
    write_cfg(CFG_SIZE_Y, sy);
    write_cfg(CFG_SIZE_Z, sz);
    write_cfg(CFG_DELTA_X, dx);
    write_cfg(CFG_DELTA_Y, dy);
    write_cfg(CFG_DELTA_Z, dz);
    write_cfg(CFG_SIGN_MASK, 32'(mask));
  endtask

  // One whole grid of random voxels with stray flushes, then the draining flushes.
  task automatic stream_grid(int nvox, int plane);
    for (int i = 0; i < nvox; i++) begin
      if ($urandom_range(19) == 0) send_item(REQ_FLUSH, $urandom, $urandom, $urandom);
      send_item(REQ_VOXEL, rand_word(), $urandom, $urandom);
    end
    if ($urandom_range(3) == 0) send_item(REQ_VOXEL, $urandom, $urandom, $urandom);
    for (int i = 0; i < plane; i++) send_item(REQ_FLUSH, $urandom, $urandom, $urandom);
    if ($urandom_range(3) == 0) send_item(REQ_FLUSH, $urandom, $urandom, $urandom);
  endtask

  task automatic run_phase(int sx, int sy, int sz, int grids, int mode, logic [6:0] mask,
                           bit full_delta);
    int csx, csy, csz;
    set_grid(sx, sy, sz,
             full_delta ? $urandom : $urandom_range(32'h0100_0000),
             full_delta ? $urandom : $urandom_range(32'h0100_0000),
             full_delta ? $urandom : $urandom_range(32'h0100_0000), mask);
    send_idle_pct  = (mode == 1) ? 80 : (mode == 3) ? 38 : 0;
    recv_stall_pct = (mode == 2) ? 80 : (mode == 3) ? 38 : 0;
    csx = (sx < 1) ? 1 : (sx > GRID_X_MAX) ? GRID_X_MAX : sx;
    csy = (sy < 1) ? 1 : (sy > GRID_Y_MAX) ? GRID_Y_MAX : sy;
    csz = (sz < 1) ? 1 : (sz > GRID_Z_MAX) ? GRID_Z_MAX : sz;
    for (int g = 0; g < grids; g++) stream_grid(csx * csy * csz, csx * csy);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Run time limit.
  initial begin
    #4ms;
    $display("FAIL seven_point_stencil_matvec_core");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [31:0] dir_val [8];
    dir_val = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                32'h1, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    sb = new();
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_wanted = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_VOXEL;
    in_if.voxel_value = '0;
    in_if.alpha = '0;
    in_if.diag_part = '0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = CFG_SIZE_X;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2x2 grid with extreme fields, early flush, full grid and idle flush.
    set_grid(2, 2, 2, 32'hFFFF_FFFF, 32'h0, 32'h0100_0000, 7'h00);
    send_item(REQ_FLUSH, '0, '0, '0);
    for (int i = 0; i < 8; i++)
      send_item(REQ_VOXEL, dir_val[i], (i % 2) ? 32'h0 : 32'hFFFF_FFFF,
                (i % 3) ? 32'hFFFF_FFFF : 32'h0);
    send_item(REQ_VOXEL, 32'h1234_5678, 32'h1, 32'h1);
    for (int i = 0; i < 5; i++) send_item(REQ_FLUSH, '1, '1, '1);
    drain();
    write_cfg(CFG_SIGN_MASK, 32'h7F);
    for (int i = 0; i < 8; i++) send_item(REQ_VOXEL, dir_val[7 - i], 32'h0100_0000, 32'h0);
    for (int i = 0; i < 4; i++) send_item(REQ_FLUSH, '0, '0, '0);
    drain();

    // Random phases across sizes, signs and idling patterns.
    run_phase(3, 4, 5, 3, 0, 7'($urandom_range(127)), 1'b0);
    run_phase(0, 0, 0, 8, 1, 7'($urandom_range(127)), 1'b1);
    run_phase(127, 1, 2, 1, 2, 7'h00, 1'b0);
    run_phase(1, 127, 0, 1, 3, SIGN_MASK_RST, 1'b0);
    hold_wanted = 1'b1;
    run_phase(1, 1, 400, 1, 0, 7'($urandom_range(127)), 1'b0);
    run_phase(5, 3, 4, 2, 3, 7'h7F, 1'b1);
    run_phase(4, 4, 3, 3, 1, 7'($urandom_range(127)), 1'b0);
    run_phase(2, 64, 1024 / 512, 1, 2, 7'($urandom_range(127)), 1'b0);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS seven_point_stencil_matvec_core");
    end else begin
      $display("FAIL seven_point_stencil_matvec_core");
    end
    $finish;
  end

endmodule
